@@ hw/rtl/lpfr_pkg.sv @@
// Shared types and fixed frame-layout constants for the length-prefixed frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

    typedef logic [7:0] byte_t;

    localparam int unsigned PLEN_W           = 6;
    localparam int unsigned HDR_BYTES        = 8;
    localparam int unsigned LEN_PREFIX_BYTES = 3;

    localparam int unsigned POS_LEN_HI  = 1;
    localparam int unsigned POS_LEN_LO  = 2;
    localparam int unsigned POS_MODULE  = 3;
    localparam int unsigned POS_COMMAND = 5;
    localparam int unsigned POS_PLEN_HI = 6;
    localparam int unsigned POS_PLEN_LO = 7;

    localparam byte_t START_BYTE_RESET = 8'hAB;

endpackage

`default_nettype wire

@@ hw/rtl/lpfr_store.sv @@
// Frame byte store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_store #(
    parameter int DEPTH = 64
) (
    input  wire                         clk,
    input  wire                         we,
    input  wire [$clog2(DEPTH)-1:0]     waddr,
    input  wire lpfr_pkg::byte_t        wdata,
    input  wire                         re,
    input  wire [$clog2(DEPTH)-1:0]     raddr,
    output lpfr_pkg::byte_t             rdata
);

    lpfr_pkg::byte_t mem [DEPTH];
    lpfr_pkg::byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/length_prefixed_frame_receiver.sv @@
// Top level of the length-prefixed frame receiver: byte intake, header checks and payload readout.
//
// Channel   Direction  Handshake             Payload
// in        in         in_valid / in_stall   rx_byte
// out       out        out_valid / out_stall module_id, command_id, payload_length,
//                                            payload_byte, byte_valid, last
// cfg       in         cfg_valid / cfg_ready start_byte
//
// One received byte is taken per cycle while a frame is being collected.
// After the completing byte, payload bytes are read back from the frame store
// at one result per cycle while out_stall is low, limited by the single read port; input is stalled
// until the last read has moved into the output register.
// Reset clears the control state and sets the start byte to 0xAB; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_receiver #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire lpfr_pkg::byte_t         rx_byte,
    output logic                         out_valid,
    input  wire                          out_stall,
    output lpfr_pkg::byte_t              module_id,
    output lpfr_pkg::byte_t              command_id,
    output logic [lpfr_pkg::PLEN_W-1:0]  payload_length,
    output lpfr_pkg::byte_t              payload_byte,
    output logic                         byte_valid,
    output logic                         last,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire lpfr_pkg::byte_t         start_byte
);

    localparam int HW       = $clog2(MAX_FRAME_BYTES + 1);
    localparam int AW       = $clog2(MAX_FRAME_BYTES);
    localparam int MIN_BODY = lpfr_pkg::HDR_BYTES - lpfr_pkg::LEN_PREFIX_BYTES;
    localparam int MAX_BODY = MAX_FRAME_BYTES - lpfr_pkg::LEN_PREFIX_BYTES;

    localparam logic ST_RX  = 1'b0;
    localparam logic ST_OUT = 1'b1;

    logic                        state_reg, state_next;
    lpfr_pkg::byte_t             start_reg;
    logic [HW-1:0]               held_reg, held_next;
    logic [HW-1:0]               expected_reg, expected_next;
    lpfr_pkg::byte_t             len_hi_reg, mod_reg, cmd_reg, plh_reg, pll_reg;
    logic [HW-1:0]               n_reg, n_next;
    logic [HW-1:0]               rd_cnt_reg, rd_cnt_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [lpfr_pkg::PLEN_W-1:0] plen_reg, plen_next;
    logic                        empty_reg, empty_next;

    logic                        out_valid_reg;
    lpfr_pkg::byte_t             out_mod_reg, out_cmd_reg, out_byte_reg;
    logic [lpfr_pkg::PLEN_W-1:0] out_plen_reg;
    logic                        out_bv_reg, out_last_reg;

    logic                        in_accept;
    logic [HW-1:0]               held_inc;
    logic [15:0]                 body;
    lpfr_pkg::byte_t             plen_lo;
    logic [8:0]                  plen_end;
    logic                        out_free;
    logic                        consume;
    logic                        rd_en;
    logic [HW:0]                 rd_addr_full;
    lpfr_pkg::byte_t             mem_q;
    logic                        mem_we;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_RX);
    assign in_accept = in_valid && !in_stall;

    assign held_inc     = held_reg + HW'(1);
    assign body         = {len_hi_reg, rx_byte};
    assign plen_lo      = (held_reg == HW'(lpfr_pkg::POS_PLEN_LO)) ? rx_byte : pll_reg;
    assign plen_end     = 9'(lpfr_pkg::HDR_BYTES) + {1'b0, plen_lo};
    assign mem_we       = in_accept && (held_reg < HW'(MAX_FRAME_BYTES));

    assign out_free     = !out_valid_reg || !out_stall;
    assign consume      = rd_pend_reg && out_free;
    assign rd_en        = (state_reg == ST_OUT) && (rd_cnt_reg < n_reg)
                          && (!rd_pend_reg || consume);
    assign rd_addr_full = (HW + 1)'(lpfr_pkg::HDR_BYTES) + {1'b0, rd_cnt_reg};

    lpfr_store #(
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (held_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (rd_en),
        .raddr (rd_addr_full[AW-1:0]),
        .rdata (mem_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        expected_next = expected_reg;
        n_next        = n_reg;
        rd_cnt_next   = rd_cnt_reg;
        rd_pend_next  = rd_pend_reg;
        plen_next     = plen_reg;
        empty_next    = empty_reg;

        unique case (state_reg)
            ST_RX:
            begin
                if (in_accept)
                begin
                    if (held_reg == '0)
                    begin
                        if (rx_byte == start_reg)
                        begin
                            held_next     = HW'(1);
                            expected_next = HW'(lpfr_pkg::LEN_PREFIX_BYTES);
                        end
                    end
                    else if (held_reg >= HW'(MAX_FRAME_BYTES))
                    begin
                        held_next     = '0;
                        expected_next = '0;
                    end
                    else if (held_reg == HW'(lpfr_pkg::POS_LEN_LO))
                    begin
                        if (body < 16'(MIN_BODY) || body > 16'(MAX_BODY))
                        begin
                            held_next     = '0;
                            expected_next = '0;
                        end
                        else
                        begin
                            held_next     = held_inc;
                            expected_next = HW'(body + 16'(lpfr_pkg::LEN_PREFIX_BYTES));
                        end
                    end
                    else if (held_inc >= expected_reg)
                    begin
                        held_next     = '0;
                        expected_next = '0;
                        if (plh_reg == '0 && plen_end <= 9'(held_inc))
                        begin
                            state_next   = ST_OUT;
                            rd_cnt_next  = '0;
                            rd_pend_next = 1'b0;
                            plen_next    = plen_lo[lpfr_pkg::PLEN_W-1:0];
                            empty_next   = (plen_lo == '0);
                            n_next       = (plen_lo == '0) ? HW'(1) : HW'(plen_lo);
                        end
                    end
                    else
                    begin
                        held_next = held_inc;
                    end
                end
            end
            ST_OUT:
            begin
                if (rd_en)
                begin
                    rd_cnt_next  = rd_cnt_reg + HW'(1);
                    rd_pend_next = 1'b1;
                end
                else if (consume)
                begin
                    rd_pend_next = 1'b0;
                end
                if (consume && rd_cnt_reg == n_reg)
                begin
                    state_next = ST_RX;
                end
            end
            default:
            begin
                state_next = ST_RX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RX;
            start_reg     <= lpfr_pkg::START_BYTE_RESET;
            held_reg      <= '0;
            expected_reg  <= '0;
            n_reg         <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            expected_reg <= expected_next;
            n_reg        <= n_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            if (cfg_valid && cfg_ready)
            begin
                start_reg <= start_byte;
            end
            if (consume)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plen_reg  <= plen_next;
        empty_reg <= empty_next;
        if (mem_we)
        begin
            case (held_reg)
                HW'(lpfr_pkg::POS_LEN_HI):  len_hi_reg <= rx_byte;
                HW'(lpfr_pkg::POS_MODULE):  mod_reg    <= rx_byte;
                HW'(lpfr_pkg::POS_COMMAND): cmd_reg    <= rx_byte;
                HW'(lpfr_pkg::POS_PLEN_HI): plh_reg    <= rx_byte;
                HW'(lpfr_pkg::POS_PLEN_LO): pll_reg    <= rx_byte;
                default:
                begin
                end
            endcase
        end
        if (consume)
        begin
            out_mod_reg  <= mod_reg;
            out_cmd_reg  <= cmd_reg;
            out_plen_reg <= plen_reg;
            out_byte_reg <= empty_reg ? 8'h00 : mem_q;
            out_bv_reg   <= !empty_reg;
            out_last_reg <= (rd_cnt_reg == n_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign module_id      = out_mod_reg;
    assign command_id     = out_cmd_reg;
    assign payload_length = out_plen_reg;
    assign payload_byte   = out_byte_reg;
    assign byte_valid     = out_bv_reg;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the length-prefixed frame receiver with directed and random framing traffic.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_BYTES    = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 95;
    localparam int DIRECTED_LEN = 25;

    // Noise, empty payload, too-short length, too-long length, then a one-byte
    // payload whose completing byte equals the start byte.
    localparam logic [8*DIRECTED_LEN-1:0] DIRECTED = {
        8'h00, 8'hFF,
        lpfr_pkg::START_BYTE_RESET, 8'h00, 8'h05, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
        lpfr_pkg::START_BYTE_RESET, 8'h00, 8'h04,
        lpfr_pkg::START_BYTE_RESET, 8'hFF, 8'hFF,
        lpfr_pkg::START_BYTE_RESET, 8'h00, 8'h06, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01,
        lpfr_pkg::START_BYTE_RESET
    };

    typedef struct packed {
        lpfr_pkg::byte_t             module_id;
        lpfr_pkg::byte_t             command_id;
        logic [lpfr_pkg::PLEN_W-1:0] payload_length;
        lpfr_pkg::byte_t             payload_byte;
        logic                        byte_valid;
        logic                        last;
    } beat_t;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    lpfr_pkg::byte_t             rx_byte    = '0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    lpfr_pkg::byte_t             module_id;
    lpfr_pkg::byte_t             command_id;
    logic [lpfr_pkg::PLEN_W-1:0] payload_length;
    lpfr_pkg::byte_t             payload_byte;
    logic                        byte_valid;
    logic                        last;
    logic                        cfg_valid  = 1'b0;
    logic                        cfg_ready;
    lpfr_pkg::byte_t             start_byte = lpfr_pkg::START_BYTE_RESET;

    lpfr_pkg::byte_t frame_copy [MAX_BYTES];
    int unsigned     bytes_in   = 0;
    int unsigned     frame_len  = 0;
    lpfr_pkg::byte_t opener     = lpfr_pkg::START_BYTE_RESET;
    beat_t           beats_due [$];
    lpfr_pkg::byte_t tx_queue [$];
    int unsigned     n_queued   = 0;
    int unsigned     n_accepted = 0;
    int unsigned     load       = 0;
    int unsigned     errors     = 0;
    int unsigned     cycles     = 0;
    int              tx_gap     = 0;
    int              rx_gap     = 0;
    bit              calm       = 1'b0;
    logic            long_hold  = 1'b0;
    event            hold_kick;

    length_prefixed_frame_receiver #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .module_id     (module_id),
        .command_id    (command_id),
        .payload_length(payload_length),
        .payload_byte  (payload_byte),
        .byte_valid    (byte_valid),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .start_byte    (start_byte)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    function automatic void absorb_byte(input lpfr_pkg::byte_t b);
        int unsigned total;
        int unsigned plen;
        int unsigned n;
        int unsigned k;
        beat_t       beat;
        if (bytes_in == 0)
        begin
            if (b == opener)
            begin
                frame_copy[0] = b;
                bytes_in      = 1;
                frame_len     = lpfr_pkg::LEN_PREFIX_BYTES;
            end
            return;
        end
        if (bytes_in >= MAX_BYTES)
        begin
            bytes_in  = 0;
            frame_len = 0;
            return;
        end
        frame_copy[bytes_in] = b;
        bytes_in++;
        if (bytes_in == lpfr_pkg::LEN_PREFIX_BYTES)
        begin
            total = lpfr_pkg::LEN_PREFIX_BYTES
                    + 32'({frame_copy[lpfr_pkg::POS_LEN_HI], frame_copy[lpfr_pkg::POS_LEN_LO]});
            if (total > MAX_BYTES || total < lpfr_pkg::HDR_BYTES)
            begin
                bytes_in  = 0;
                frame_len = 0;
                return;
            end
            frame_len = total;
        end
        if (bytes_in < frame_len)
            return;
        total     = bytes_in;
        bytes_in  = 0;
        frame_len = 0;
        plen      = 32'({frame_copy[lpfr_pkg::POS_PLEN_HI], frame_copy[lpfr_pkg::POS_PLEN_LO]});
        if (lpfr_pkg::HDR_BYTES + plen > total)
            return;
        n = (plen == 0) ? 1 : plen;
        for (k = 0; k < n; k++)
        begin
            beat.module_id      = frame_copy[lpfr_pkg::POS_MODULE];
            beat.command_id     = frame_copy[lpfr_pkg::POS_COMMAND];
            beat.payload_length = plen[lpfr_pkg::PLEN_W-1:0];
            beat.payload_byte   = (plen == 0) ? '0 : frame_copy[lpfr_pkg::HDR_BYTES + k];
            beat.byte_valid     = (plen != 0);
            beat.last           = (k + 1 == n);
            beats_due.push_back(beat);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        errors++;
        $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $time);
    endtask

    task automatic check_beat();
        beat_t want;
        if (beats_due.size() == 0)
        begin
            report_mismatch("transaction with nothing pending", '0, {8'h00, payload_byte});
            return;
        end
        want = beats_due.pop_front();
        if (module_id !== want.module_id)
            report_mismatch("module_id", 16'(want.module_id), 16'(module_id));
        if (command_id !== want.command_id)
            report_mismatch("command_id", 16'(want.command_id), 16'(command_id));
        if (payload_length !== want.payload_length)
            report_mismatch("payload_length", 16'(want.payload_length), 16'(payload_length));
        if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
        if (byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 16'(want.byte_valid), 16'(byte_valid));
        if (last !== want.last)
            report_mismatch("last", 16'(want.last), 16'(last));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                absorb_byte(rx_byte);
                n_accepted++;
            end
            if (!(in_valid && in_stall))
            begin
                if (tx_gap > 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (tx_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= tx_queue.pop_front();
                    tx_gap   <= pick_wait();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : rx_side
        int w;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_gap    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_beat();
            if (long_hold)
            begin
                out_stall <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                w = pick_wait();
                rx_gap    <= w;
                out_stall <= (w != 0);
            end
            else if (rx_gap > 1)
            begin
                rx_gap    <= rx_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                rx_gap    <= 0;
                out_stall <= 1'b0;
            end
        end
    end

    always
    begin
        @(hold_kick);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    task automatic send(input lpfr_pkg::byte_t b, input bit counts);
        tx_queue.push_back(b);
        n_queued++;
        if (counts)
            load++;
    endtask

    task automatic queue_frame();
        int unsigned     shape;
        int unsigned     twist;
        int unsigned     total;
        int unsigned     room;
        int unsigned     len;
        int unsigned     plen;
        int unsigned     cut;
        int unsigned     i;
        lpfr_pkg::byte_t b;
        shape = $urandom_range(0, 99);
        twist = $urandom_range(0, 99);
        if (shape < 10)
            total = lpfr_pkg::HDR_BYTES;
        else if (shape < 18)
            total = MAX_BYTES;
        else
            total = $urandom_range(lpfr_pkg::HDR_BYTES + 1, 24);
        room = total - lpfr_pkg::HDR_BYTES;
        len  = total - lpfr_pkg::LEN_PREFIX_BYTES;
        plen = ($urandom_range(0, 2) == 0) ? room : $urandom_range(0, room);
        cut  = total;
        if (twist < 10)
        begin
            len = $urandom_range(0, 1) ? $urandom_range(0, 4)
                                       : $urandom_range(MAX_BYTES - 2, 16'hFFFF);
            cut = lpfr_pkg::LEN_PREFIX_BYTES;
        end
        else if (twist < 18)
        begin
            plen = $urandom_range(0, 1) ? room + $urandom_range(1, 8)
                                        : $urandom_range(room + 1, 16'hFFFF);
        end
        else if (twist < 23)
        begin
            cut = $urandom_range(1, total - 1);
        end
        for (i = 0; i < cut; i++)
        begin
            b = lpfr_pkg::byte_t'($urandom);
            if (i == 0)
                b = opener;
            else if (i == lpfr_pkg::POS_LEN_HI)
                b = len[15:8];
            else if (i == lpfr_pkg::POS_LEN_LO)
                b = len[7:0];
            else if (i == lpfr_pkg::POS_PLEN_HI)
                b = plen[15:8];
            else if (i == lpfr_pkg::POS_PLEN_LO)
                b = plen[7:0];
            send(b, 1'b1);
        end
        repeat ($urandom_range(0, 2))
        begin
            do
                b = lpfr_pkg::byte_t'($urandom);
            while (b == opener);
            send(b, 1'b0);
        end
    endtask

    task automatic run_random(input int unsigned amount);
        load = 0;
        while (load < amount)
            queue_frame();
    endtask

    task automatic drain();
        while (n_accepted != n_queued || beats_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_opener(input lpfr_pkg::byte_t value);
        @(posedge clk);
        cfg_valid  <= 1'b1;
        start_byte <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        opener = value;
    endtask

    initial
    begin : stimulus
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_LEN; i++)
            send(DIRECTED[8*(DIRECTED_LEN-1-i) +: 8], 1'b1);
        drain();

        set_opener(8'h00);
        run_random(PHASE_ITEMS);
        drain();

        set_opener(8'hFF);
        run_random(PHASE_ITEMS);
        @(posedge clk);
        -> hold_kick;
        drain();

        calm = 1'b1;
        set_opener(lpfr_pkg::byte_t'($urandom_range(1, 254)));
        run_random(PHASE_ITEMS);
        drain();
        calm = 1'b0;

        set_opener(lpfr_pkg::START_BYTE_RESET);
        run_random(PHASE_ITEMS);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lpfr_pkg.sv
hw/rtl/lpfr_store.sv
hw/rtl/length_prefixed_frame_receiver.sv
tb/tb.sv
